// ----- src/clr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and colour packing for the line rasteriser.
package clr_pkg;

  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 480;
  localparam int unsigned DEPTH         = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned ADDR_W        = $clog2(DEPTH);
  localparam int unsigned X_IDX_W       = $clog2(SCREEN_WIDTH);
  localparam int unsigned Y_IDX_W       = $clog2(SCREEN_HEIGHT);

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COUNT_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_RADDR,
    ST_RDATA,
    ST_DONE
  } state_e;

  // RGB565 to RGB332: keep the top bits of each channel
  function automatic logic [PIX_W-1:0] pack_332(input logic [COLOR_W-1:0] color);
    return {color[15:13], color[10:8], color[4:3]};
  endfunction

endpackage

// ----- src/clr_cmd_if.sv -----
`timescale 1ns / 1ps
// Command channel: draw or read request with endpoints and colour.
interface clr_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [15:0] end_x;
  logic [15:0] end_y;
  logic [15:0] color;

  modport source (output valid, command, start_x, start_y, end_x, end_y, color,
                  input ready);
  modport sink   (input valid, command, start_x, start_y, end_x, end_y, color,
                  output ready);
endinterface

// ----- src/clr_res_if.sv -----
`timescale 1ns / 1ps
// Result channel: pixel read back and count of pixels stored.
interface clr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic [9:0] pixels_written;

  modport source (output valid, read_value, pixels_written, input ready);
  modport sink   (input valid, read_value, pixels_written, output ready);
endinterface

// ----- src/clipped_line_rasterizer.sv -----
`timescale 1ns / 1ps
// Bresenham line rasteriser with per-pixel clipping into an RGB332 frame store.
//
// Usage:
//   cmd_i carries one command per item. A draw (command 0) walks the line from
//   the start point to the end point, both included, storing the colour packed
//   to RGB332 at every pixel on the 320 x 480 panel. A read (command 1) returns
//   the stored pixel at the start point, or 0 when that point is off the panel.
//   res_o gives exactly one item per command, in command order.
// Timing:
//   A draw steps one pixel per cycle in the single error/step unit, then loads
//   its result. A read goes through address multiply, store read and result
//   load. cmd_i.ready is high only in the idle state, entered in the cycle
//   after the result loads; a new command may be taken while the previous
//   result still sits in the register.
// Reset:
//   Control state and the output register valid clear; the frame store is not
//   cleared and reads of pixels never drawn return undefined data.
// Stall:
//   When res_o.ready is low the result is held and a finished command waits
//   in its last state until the output register frees up.
module clipped_line_rasterizer (
  input  logic   clk_i,
  input  logic   rst_ni,
  clr_cmd_if.sink   cmd_i,
  clr_res_if.source res_o
);
  import clr_pkg::*;

  state_e state_q, state_d;

  logic [COORD_W-1:0] x_q, y_q, x1_q, y1_q;
  logic               sx_neg_q, sy_neg_q;
  logic signed [16:0] dx_q, dy_q;
  logic signed [18:0] err_q;
  logic [PIX_W-1:0]   pix_q;
  logic [COUNT_W-1:0] count_q;

  logic [ADDR_W-1:0]  addr_q;
  logic               onp_q;
  logic               wr_q;
  logic [PIX_W-1:0]   rd_data_q;

  logic               out_valid_q;
  logic [PIX_W-1:0]   out_value_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               cmd_q;

  logic               accept;
  logic               out_load;
  logic               on_panel;
  logic               at_end;
  logic [ADDR_W-1:0]  addr_calc;

  logic [COORD_W-1:0] adx, ady;
  logic signed [16:0] dx_init, dy_init;
  logic signed [19:0] e2, dx_ext, dy_ext;
  logic               step_x, step_y;
  logic signed [18:0] err_next;

  logic [PIX_W-1:0]  frame_mem [DEPTH];

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);
  assign on_panel = (x_q < COORD_W'(SCREEN_WIDTH)) && (y_q < COORD_W'(SCREEN_HEIGHT));
  assign at_end   = (x_q == x1_q) && (y_q == y1_q);
  assign addr_calc = ADDR_W'(y_q[Y_IDX_W-1:0]) * ADDR_W'(SCREEN_WIDTH)
                   + ADDR_W'(x_q[X_IDX_W-1:0]);

  // Line setup from the command
  assign adx = (cmd_i.start_x < cmd_i.end_x) ? cmd_i.end_x - cmd_i.start_x
                                             : cmd_i.start_x - cmd_i.end_x;
  assign ady = (cmd_i.start_y < cmd_i.end_y) ? cmd_i.end_y - cmd_i.start_y
                                             : cmd_i.start_y - cmd_i.end_y;
  assign dx_init = signed'({1'b0, adx});
  assign dy_init = -signed'({1'b0, ady});

  // Shared error/step unit
  assign e2     = {err_q, 1'b0};
  assign dx_ext = 20'(dx_q);
  assign dy_ext = 20'(dy_q);
  assign step_x = (e2 >= dy_ext);
  assign step_y = (e2 <= dx_ext);
  assign err_next = err_q + (step_x ? 19'(dy_q) : 19'sd0) + (step_y ? 19'(dx_q) : 19'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= (state_q == ST_DRAW) && on_panel;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid) begin
          state_d = (cmd_i.command == CMD_READ) ? ST_RADDR : ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (at_end) begin
          state_d = ST_DONE;
        end
      end
      ST_RADDR: state_d = ST_RDATA;
      ST_RDATA: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_calc;
    onp_q  <= on_panel;
    if (accept) begin
      x_q      <= cmd_i.start_x;
      y_q      <= cmd_i.start_y;
      x1_q     <= cmd_i.end_x;
      y1_q     <= cmd_i.end_y;
      sx_neg_q <= !(cmd_i.start_x < cmd_i.end_x);
      sy_neg_q <= !(cmd_i.start_y < cmd_i.end_y);
      dx_q     <= dx_init;
      dy_q     <= dy_init;
      err_q    <= 19'(dx_init) + 19'(dy_init);
      pix_q    <= pack_332(cmd_i.color);
      cmd_q    <= cmd_i.command;
      count_q  <= '0;
    end else if (state_q == ST_DRAW) begin
      if (on_panel && (count_q != COUNT_MAX)) begin
        count_q <= count_q + COUNT_W'(1);
      end
      if (!at_end) begin
        err_q <= err_next;
        if (step_x) begin
          x_q <= sx_neg_q ? x_q - COORD_W'(1) : x_q + COORD_W'(1);
        end
        if (step_y) begin
          y_q <= sy_neg_q ? y_q - COORD_W'(1) : y_q + COORD_W'(1);
        end
      end
    end
    if (out_load) begin
      out_value_q <= (cmd_q == CMD_READ && onp_q) ? rd_data_q : '0;
      out_count_q <= (cmd_q == CMD_READ) ? '0 : count_q;
    end
  end

  // Frame store: one write port from the step unit, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_q) begin
      frame_mem[addr_q] <= pix_q;
    end
    if (state_q == ST_RDATA) begin
      rd_data_q <= frame_mem[addr_q];
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.read_value     = out_value_q;
  assign res_o.pixels_written = out_count_q;

  a_wr_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q |-> $past(state_q == ST_DRAW))
    else $error("frame store write outside a draw");

  a_res_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == ST_DONE))
    else $error("result raised without a finished command");

  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.command == CMD_READ) |=> (state_q == ST_RADDR))
    else $error("read command did not enter the address state");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.pixels_written != '0) |-> (res_o.read_value == '0))
    else $error("draw result carries a read value");

endmodule
